// File: hw/rtl/msp_pkg.sv
package msp_pkg;

	// fixed field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned ACC_W    = 25;
	localparam int unsigned TOL_W    = 8;
	localparam int unsigned RUN_W    = 8;
	localparam int unsigned PCT_W    = 7;

	// filter defaults
	localparam int unsigned FILTER_SHIFT_DEF  = 4;
	localparam int unsigned FRACTION_BITS_DEF = 8;

	// percentage scale
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

	// divider sizing: num and den are below 2^16, quotient below 128
	localparam int unsigned DIV_W   = 16;
	localparam int unsigned REM_W   = DIV_W + PCT_W;
	localparam int unsigned STEP_W  = 3;

	// queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// register port
	localparam int unsigned APB_DW = 32;
	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_WET = 2'd0,
		REG_DRY = 2'd1,
		REG_TOL = 2'd2,
		REG_RUN = 2'd3
	} reg_idx_t;

	localparam logic signed [SAMPLE_W-1:0] WET_RST = 16'sd0;
	localparam logic signed [SAMPLE_W-1:0] DRY_RST = 16'sd0;
	localparam logic [TOL_W-1:0]           TOL_RST = 8'd3;
	localparam logic [RUN_W-1:0]           RUN_RST = 8'd5;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smoothed;
		logic                       stable;
	} entry_t;

endpackage

// File: hw/rtl/moisture_smooth_stability_percent.sv
// result path: a pushed sample is written to the queue, then the back end loads it and
// either clamps the percentage at 0 or 100 or works it out in the divider
// back end: load, 7 quotient bits and out for a divided result, load and out if clamped;
// the 7-step restoring divider makes the quotient bits; the next entry waits for a pop
// front end takes a beat every cycle until the two-entry queue fills
// reset: arst_n clears filter, run count, previous value, queue and config to defaults
module moisture_smooth_stability_percent #(
	parameter int unsigned FILTER_SHIFT  = msp_pkg::FILTER_SHIFT_DEF,
	parameter int unsigned FRACTION_BITS = msp_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample side
	input  logic                                push,
	output logic                                full,
	input  logic signed [msp_pkg::SAMPLE_W-1:0] sample_mv,
	// result side
	output logic                                empty,
	input  logic                                pop,
	output logic signed [msp_pkg::SAMPLE_W-1:0] smoothed_mv,
	output logic                                stable,
	output logic [msp_pkg::PCT_W-1:0]           moisture_percent,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [msp_pkg::ADDR_W-1:0]          paddr,
	input  logic [msp_pkg::APB_DW-1:0]          pwdata,
	output logic [msp_pkg::APB_DW-1:0]          prdata,
	output logic                                pready
);

	localparam int unsigned SMP_W = msp_pkg::SAMPLE_W;
	localparam int unsigned DW    = msp_pkg::APB_DW;

	// config registers
	logic signed [SMP_W-1:0]        wet_q;
	logic signed [SMP_W-1:0]        dry_q;
	logic [msp_pkg::TOL_W-1:0]      tol_q;
	logic [msp_pkg::RUN_W-1:0]      run_q;

	logic                           cfg_wr;
	msp_pkg::reg_idx_t              reg_idx;

	// front to queue and queue to back
	logic                           q_push;
	logic                           q_full;
	logic                           q_pop;
	logic                           q_empty;
	msp_pkg::entry_t                q_wr_data;
	msp_pkg::entry_t                q_rd_data;

	// register port: word index from the address, no wait states
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = msp_pkg::reg_idx_t'(paddr[msp_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q <= msp_pkg::WET_RST;
			dry_q <= msp_pkg::DRY_RST;
			tol_q <= msp_pkg::TOL_RST;
			run_q <= msp_pkg::RUN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				msp_pkg::REG_WET: wet_q <= pwdata[SMP_W-1:0];
				msp_pkg::REG_DRY: dry_q <= pwdata[SMP_W-1:0];
				msp_pkg::REG_TOL: tol_q <= pwdata[msp_pkg::TOL_W-1:0];
				msp_pkg::REG_RUN: run_q <= pwdata[msp_pkg::RUN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// readback, thresholds sign extended
	always_comb begin
		case (reg_idx)
			msp_pkg::REG_WET: prdata = DW'(wet_q);
			msp_pkg::REG_DRY: prdata = DW'(dry_q);
			msp_pkg::REG_TOL: prdata = DW'(tol_q);
			msp_pkg::REG_RUN: prdata = DW'(run_q);
			default:          prdata = '0;
		endcase
	end

	// front: filter update and run detection, one beat per cycle while the queue has room
	msp_front #(
		.FILTER_SHIFT  (FILTER_SHIFT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_mv  (sample_mv),
		.tolerance  (tol_q),
		.run_length (run_q),
		.q_push     (q_push),
		.q_data     (q_wr_data),
		.q_full     (q_full)
	);

	// short queue decouples the filter from the divider
	msp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	// back: percentage mapping and result register
	msp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.q_data           (q_rd_data),
		.wet              (wet_q),
		.dry              (dry_q),
		.empty            (empty),
		.pop              (pop),
		.smoothed_mv      (smoothed_mv),
		.stable           (stable),
		.moisture_percent (moisture_percent)
	);

endmodule

// File: hw/rtl/msp_queue.sv
module msp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  msp_pkg::entry_t wr_data,
	output logic            full,
	input  logic            pop,
	output msp_pkg::entry_t rd_data,
	output logic            empty
);

	localparam int unsigned DEPTH = msp_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	msp_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not drain queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("queue empty after push");

endmodule

// File: hw/rtl/msp_front.sv
module msp_front #(
	parameter int unsigned FILTER_SHIFT  = msp_pkg::FILTER_SHIFT_DEF,
	parameter int unsigned FRACTION_BITS = msp_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [msp_pkg::SAMPLE_W-1:0] sample_mv,
	input  logic [msp_pkg::TOL_W-1:0]           tolerance,
	input  logic [msp_pkg::RUN_W-1:0]           run_length,
	output logic                                q_push,
	output msp_pkg::entry_t                     q_data,
	input  logic                                q_full
);

	localparam int unsigned ACC_W    = msp_pkg::ACC_W;
	localparam int unsigned SMP_W    = msp_pkg::SAMPLE_W;
	localparam int unsigned SCALED_W = SMP_W + FRACTION_BITS;
	localparam int unsigned MUL_W    = ACC_W + FILTER_SHIFT;
	localparam int unsigned SUM_W    = ((MUL_W > SCALED_W) ? MUL_W : SCALED_W) + 1;
	localparam int unsigned DIFF_W   = SMP_W + 1;

	logic signed [ACC_W-1:0]            acc_q;
	logic signed [SMP_W-1:0]            prev_q;
	logic [msp_pkg::RUN_W-1:0]          cnt_q;

	logic signed [SUM_W-1:0]            acc_ext;
	logic signed [SUM_W-1:0]            acc_weighted;
	logic signed [SUM_W-1:0]            scaled;
	logic signed [SUM_W-1:0]            sum;
	logic signed [SUM_W-1:0]            sum_sh;
	logic signed [ACC_W-1:0]            acc_nxt;
	logic signed [ACC_W-1:0]            smooth_full;
	logic signed [SMP_W-1:0]            smooth;
	logic signed [DIFF_W-1:0]           diff;
	logic [DIFF_W-1:0]                  diff_abs;
	logic                               steady;
	logic [msp_pkg::RUN_W-1:0]          cnt_mid;
	logic                               hit;
	logic                               accept;

	// acc * (2^shift - 1) as a shift and subtract
	assign acc_ext      = SUM_W'(acc_q);
	assign acc_weighted = (acc_ext <<< FILTER_SHIFT) - acc_ext;
	assign scaled       = SUM_W'(sample_mv) <<< FRACTION_BITS;
	assign sum          = acc_weighted + scaled;
	assign sum_sh       = sum >>> FILTER_SHIFT;
	assign acc_nxt      = sum_sh[ACC_W-1:0];
	assign smooth_full  = acc_nxt >>> FRACTION_BITS;
	assign smooth       = smooth_full[SMP_W-1:0];

	assign diff     = DIFF_W'(prev_q) - DIFF_W'(smooth);
	assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign steady   = (diff_abs <= DIFF_W'(tolerance));
	assign cnt_mid  = steady ? cnt_q + 1'b1 : '0;
	assign hit      = (cnt_mid >= run_length);

	assign full            = q_full;
	assign accept          = push && !q_full;
	assign q_push          = accept;
	assign q_data.smoothed = smooth;
	assign q_data.stable   = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			prev_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			acc_q  <= acc_nxt;
			prev_q <= hit ? '0 : smooth;
			cnt_q  <= hit ? '0 : cnt_mid;
		end
	end

endmodule

// File: hw/rtl/msp_back.sv
module msp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  msp_pkg::entry_t                     q_data,
	input  logic signed [msp_pkg::SAMPLE_W-1:0] wet,
	input  logic signed [msp_pkg::SAMPLE_W-1:0] dry,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [msp_pkg::SAMPLE_W-1:0] smoothed_mv,
	output logic                                stable,
	output logic [msp_pkg::PCT_W-1:0]           moisture_percent
);

	localparam int unsigned SMP_W  = msp_pkg::SAMPLE_W;
	localparam int unsigned DIV_W  = msp_pkg::DIV_W;
	localparam int unsigned REM_W  = msp_pkg::REM_W;
	localparam int unsigned STEP_W = msp_pkg::STEP_W;
	localparam int unsigned PCT_W  = msp_pkg::PCT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t                  state_q;
	logic [REM_W-1:0]        rem_q;
	logic [DIV_W-1:0]        den_q;
	logic [STEP_W-1:0]       step_q;
	logic [PCT_W-1:0]        pct_q;
	logic signed [SMP_W-1:0] smooth_q;
	logic                    stable_q;

	logic signed [SMP_W:0]   num_wide;
	logic signed [SMP_W:0]   den_wide;
	logic [REM_W-1:0]        trial;
	logic                    fits;

	assign num_wide = (SMP_W + 1)'(dry) - (SMP_W + 1)'(q_data.smoothed);
	assign den_wide = (SMP_W + 1)'(dry) - (SMP_W + 1)'(wet);
	assign trial    = REM_W'(den_q) << step_q;
	assign fits     = (rem_q >= trial);

	assign q_pop            = (state_q == ST_IDLE) && !q_empty;
	assign empty            = (state_q != ST_OUT);
	assign smoothed_mv      = smooth_q;
	assign stable           = stable_q;
	assign moisture_percent = pct_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			smooth_q <= q_data.smoothed;
			stable_q <= q_data.stable;
			rem_q    <= REM_W'(num_wide[DIV_W-1:0]) * REM_W'(msp_pkg::PCT_FULL);
			den_q    <= den_wide[DIV_W-1:0];
		end else if (state_q == ST_DIV && fits) begin
			rem_q <= rem_q - trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			pct_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_data.smoothed <= wet) begin
							pct_q   <= msp_pkg::PCT_FULL;
							state_q <= ST_OUT;
						end else if (q_data.smoothed >= dry) begin
							pct_q   <= msp_pkg::PCT_NONE;
							state_q <= ST_OUT;
						end else begin
							pct_q   <= '0;
							step_q  <= STEP_W'(PCT_W - 1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					pct_q <= {pct_q[PCT_W-2:0], fits};
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (moisture_percent <= msp_pkg::PCT_FULL))
		else $error("percentage above full scale");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |->
			((REM_W + 1)'(rem_q) < ((REM_W + 1)'(den_q) << ((STEP_W + 1)'(step_q) + 1'b1))))
		else $error("divider remainder out of range");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != ST_IDLE))
		else $error("queue beat taken without starting work");

endmodule

// File: verif/tb_moisture_smooth_stability_percent.sv
module tb_moisture_smooth_stability_percent;

	localparam int unsigned SAMPLE_W = msp_pkg::SAMPLE_W;
	localparam int unsigned ACC_W    = msp_pkg::ACC_W;
	localparam int unsigned TOL_W    = msp_pkg::TOL_W;
	localparam int unsigned RUN_W    = msp_pkg::RUN_W;
	localparam int unsigned PCT_W    = msp_pkg::PCT_W;
	localparam int unsigned APB_DW   = msp_pkg::APB_DW;
	localparam int unsigned ADDR_W   = msp_pkg::ADDR_W;

	// clock period 8, long enough timeout for the slowest legal run
	localparam int  SETTLE_CYCLES = 24;   // room for a divided result, plus slack
	localparam int  LONG_HOLD     = 300;  // receiver back-pressure stretch
	localparam int  RANDOM_PHASES = 8;
	localparam int  PHASE_BEATS   = 140;  // about 1100 random samples in total
	localparam longint ACC_WEIGHT = (longint'(1) << msp_pkg::FILTER_SHIFT_DEF) - 1;

	// one result beat as the block presents it
	typedef struct {
		logic signed [SAMPLE_W-1:0] smoothed;
		logic                       stable;
		logic [PCT_W-1:0]           percent;
	} reading_t;

	// tracks the filter, the steady-run detector and the percent mapping,
	// and holds the readings still owed by the block
	class reading_tracker;
		logic signed [SAMPLE_W-1:0] wet_mv  = msp_pkg::WET_RST;
		logic signed [SAMPLE_W-1:0] dry_mv  = msp_pkg::DRY_RST;
		logic [TOL_W-1:0]           tol_mv  = msp_pkg::TOL_RST;
		logic [RUN_W-1:0]           run_len = msp_pkg::RUN_RST;
		logic signed [ACC_W-1:0]    filt_acc   = '0;
		logic signed [SAMPLE_W-1:0] prev_mv    = '0;
		logic [RUN_W-1:0]           steady_cnt = '0;
		reading_t                   owed_readings[$];
		int                         mismatches = 0;

		function void set_reg(msp_pkg::reg_idx_t idx, logic [APB_DW-1:0] v);
			case (idx)
				msp_pkg::REG_WET: wet_mv  = v[SAMPLE_W-1:0];
				msp_pkg::REG_DRY: dry_mv  = v[SAMPLE_W-1:0];
				msp_pkg::REG_TOL: tol_mv  = v[TOL_W-1:0];
				msp_pkg::REG_RUN: run_len = v[RUN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PCT_W-1:0] level_to_percent(logic signed [SAMPLE_W-1:0] lvl);
			int v, w, d;
			v = lvl;
			w = wet_mv;
			d = dry_mv;
			// wet test first, so an inverted pair never reaches the divide
			if (v <= w)
				return msp_pkg::PCT_FULL;
			if (v >= d)
				return msp_pkg::PCT_NONE;
			return PCT_W'((d - v) * 100 / (d - w));
		endfunction

		// sample beat accepted: advance the filter and queue the reading
		function void note_sample(logic signed [SAMPLE_W-1:0] s);
			longint   sum;
			int       delta;
			reading_t r;
			sum = longint'(filt_acc) * ACC_WEIGHT
				+ (longint'(s) <<< msp_pkg::FRACTION_BITS_DEF);
			filt_acc   = ACC_W'(sum >>> msp_pkg::FILTER_SHIFT_DEF);
			r.smoothed = SAMPLE_W'(filt_acc >>> msp_pkg::FRACTION_BITS_DEF);
			delta = int'(prev_mv) - int'(r.smoothed);
			if (delta < 0)
				delta = -delta;
			if (delta > int'(tol_mv))
				steady_cnt = '0;
			else
				steady_cnt = steady_cnt + 1'b1;
			prev_mv  = r.smoothed;
			r.stable = 1'b0;
			// run complete: flag it and start over from zero
			if (steady_cnt >= run_len) begin
				r.stable   = 1'b1;
				steady_cnt = '0;
				prev_mv    = '0;
			end
			r.percent = level_to_percent(r.smoothed);
			owed_readings.push_back(r);
		endfunction

		function void check_reading(logic signed [SAMPLE_W-1:0] sm, logic st,
				logic [PCT_W-1:0] pct);
			reading_t r;
			if (owed_readings.size() == 0) begin
				$error("result beat with no reading owed: smoothed_mv %0d", sm);
				mismatches++;
				return;
			end
			r = owed_readings.pop_front();
			if (sm !== r.smoothed) begin
				$error("smoothed_mv: expected %0d, got %0d", r.smoothed, sm);
				mismatches++;
			end
			if (st !== r.stable) begin
				$error("stable: expected %0d, got %0d", r.stable, st);
				mismatches++;
			end
			if (pct !== r.percent) begin
				$error("moisture_percent: expected %0d, got %0d", r.percent, pct);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return owed_readings.size();
		endfunction
	endclass

	logic                    clk     = 1'b0;
	logic                    arst_n  = 1'b0;
	logic                    push    = 1'b0;
	logic                    full;
	logic signed [SAMPLE_W-1:0] sample_mv = '0;
	logic                    empty;
	logic                    pop     = 1'b0;
	logic signed [SAMPLE_W-1:0] smoothed_mv;
	logic                    stable;
	logic [PCT_W-1:0]        moisture_percent;
	logic                    psel    = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite  = 1'b0;
	logic [ADDR_W-1:0]       paddr   = '0;
	logic [APB_DW-1:0]       pwdata  = '0;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;

	reading_tracker readings = new();

	// pacing knobs, changed by the main sequence between phases
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_request  = 1'b0;
	int hold_left     = 0;
	logic signed [SAMPLE_W-1:0] cur_level = '0;

	moisture_smooth_stability_percent u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.sample_mv        (sample_mv),
		.empty            (empty),
		.pop              (pop),
		.smoothed_mv      (smoothed_mv),
		.stable           (stable),
		.moisture_percent (moisture_percent),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: pop decided at the falling edge, long hold counted here
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop = 1'b0;
		end else begin
			pop = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result beat taken at the rising edge, values as they stood before it
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			readings.check_reading(smoothed_mv, stable, moisture_percent);
	end

	// one sample beat, with random gaps in front; returns at a falling edge
	task automatic push_sample(logic signed [SAMPLE_W-1:0] s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push      = 1'b1;
		sample_mv = s;
		@(posedge clk);
		while (full)
			@(posedge clk);
		readings.note_sample(s);
		@(negedge clk);
	endtask

	// setup then access; the register takes the value on the access edge
	task automatic write_reg(msp_pkg::reg_idx_t idx, logic [APB_DW-1:0] v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		readings.set_reg(idx, v);
	endtask

	// unused upper data bits carry junk to show they are ignored
	task automatic apply_settings(logic signed [SAMPLE_W-1:0] wet,
			logic signed [SAMPLE_W-1:0] dry, logic [TOL_W-1:0] tol, logic [RUN_W-1:0] run);
		write_reg(msp_pkg::REG_WET, {16'($urandom), wet});
		write_reg(msp_pkg::REG_DRY, {16'($urandom), dry});
		write_reg(msp_pkg::REG_TOL, {24'($urandom), tol});
		write_reg(msp_pkg::REG_RUN, {24'($urandom), run});
	endtask

	// all readings back, then a quiet settle period so the block is idle
	task automatic drain();
		push = 1'b0;
		while (readings.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_pacing(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 64; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 64; end
			default: begin send_idle_pct = 19; stall_pct = 19; end
		endcase
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SAMPLE_W'(int'(readings.wet_mv) + int'($urandom_range(0, 64)) - 32);
			3: return SAMPLE_W'(int'(readings.dry_mv) + int'($urandom_range(0, 64)) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// mostly steady stretches around a drifting level so runs complete,
	// with short bursts of junk that break them
	task automatic run_levels(int beats);
		int left, seg, spread, t;
		left = beats;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				seg = $urandom_range(1, 4);
				for (int i = 0; i < seg && left > 0; i++) begin
					push_sample(SAMPLE_W'($urandom));
					left--;
				end
			end else begin
				if ($urandom_range(0, 9) < 3)
					cur_level = pick_level();
				else
					cur_level = SAMPLE_W'(int'(cur_level) + int'($urandom_range(0, 128)) - 64);
				case ($urandom_range(0, 3))
					0: spread = 0;
					1: spread = 2;
					2: spread = 8;
					default: spread = 100;
				endcase
				seg = $urandom_range(4, 40);
				for (int i = 0; i < seg && left > 0; i++) begin
					t = int'(cur_level) + int'($urandom_range(0, 2 * spread)) - spread;
					push_sample(SAMPLE_W'(t));
					left--;
				end
			end
		end
	endtask

	initial begin
		logic signed [SAMPLE_W-1:0] w, d, tmp;
		logic [TOL_W-1:0] tol;
		logic [RUN_W-1:0] run;

		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset settings: wet equals dry, so only 0 or 100
		set_pacing(0);
		// six flat zeros finish a default run of five and restart it
		repeat (6)
			push_sample(16'sd0);
		repeat (3)
			push_sample(16'sh7fff);
		repeat (3)
			push_sample(16'sh8000);
		drain();

		// zero run length: every beat is stable, widest tolerance
		apply_settings(-16'sd20000, 16'sd20000, 8'd255, 8'd0);
		push_sample(16'sh7fff);
		push_sample(16'sh7fff);
		push_sample(16'sh8000);
		push_sample(16'sd0);
		drain();

		// wet above dry, tightest tolerance, longest run
		apply_settings(16'sd30000, -16'sd30000, 8'd0, 8'd255);
		push_sample(16'sd5000);
		push_sample(-16'sd5000);
		push_sample(16'sh7fff);
		push_sample(16'sh8000);
		drain();

		// full thresholds so the divider sees its widest span
		apply_settings(16'sh8000, 16'sh7fff, 8'd3, 8'd1);
		push_sample(16'sd1234);
		push_sample(16'sd1234);
		push_sample(-16'sd700);
		drain();

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			case (k)
				0: begin w = 16'sh8000; d = 16'sh7fff; tol = 8'd0; run = 8'd255; end
				1: begin w = 16'sh7fff; d = 16'sh8000; tol = 8'd255; run = 8'd0; end
				default: begin
					w = SAMPLE_W'($urandom);
					d = SAMPLE_W'($urandom);
					// ordered pair most of the time so percentages land mid-scale
					if ($urandom_range(0, 3) != 0 && w > d) begin
						tmp = w;
						w   = d;
						d   = tmp;
					end
					case ($urandom_range(0, 3))
						0: tol = 8'd0;
						1: tol = 8'd255;
						default: tol = TOL_W'($urandom_range(1, 12));
					endcase
					case ($urandom_range(0, 4))
						0: run = 8'd0;
						1: run = 8'd1;
						2: run = 8'd255;
						default: run = RUN_W'($urandom_range(2, 12));
					endcase
				end
			endcase
			apply_settings(w, d, tol, run);
			set_pacing(k);
			// receiver goes quiet while samples keep coming, so full must rise
			if (k == 4)
				hold_request = 1'b1;
			run_levels(PHASE_BEATS);
			drain();
		end

		if (readings.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#3200000;
		$display("simulation failed");
		$finish;
	end

endmodule
